// File: rtl/hsv_frame_morph_buffer_top_defines.svh
// ----------------------------------------------------------------------------
// HSV frame morph buffer assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef HSV_FRAME_MORPH_BUFFER_TOP_DEFINES_SVH
`define HSV_FRAME_MORPH_BUFFER_TOP_DEFINES_SVH

// same-cycle implication
`define HFMB_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define HFMB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/hfmb_pkg.sv
// ----------------------------------------------------------------------------
// hfmb_pkg
// Types, codes and arithmetic helpers shared by the frame morph buffer.
// ----------------------------------------------------------------------------
package hfmb_pkg;

  localparam int unsigned NumPixelsDefault = 128;
  localparam logic [7:0]  RedLo            = 8'd224;
  localparam logic [7:0]  RedWidth         = 8'd64;   // 32 - 224, mod 256

  typedef enum logic [2:0] {
    MODE_WR_MAP = 3'd0,
    MODE_WR_RAW = 3'd1,
    MODE_DIM    = 3'd2,
    MODE_PUSH   = 3'd3,
    MODE_MORPH  = 3'd4,
    MODE_MAP_LD = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ONLY_RED = 2'd0,
    CFG_BLUR     = 2'd1,
    CFG_MAP_EN   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAP,
    ST_PIX,
    ST_DIV,
    ST_BLEND,
    ST_PUSH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture input beat
    logic use_map;    // pixel address from map read data
    logic phys_ld;    // capture physical index
    logic map_wr;     // write map entry
    logic div_start;  // start fract divider
    logic px_latch;   // capture current/next pixels
    logic pix_write;  // color write into next frame
    logic dim_write;  // dim next-frame pixel
    logic blend;      // compute morph result
    logic push_clr;   // reset sweep counter
    logic push_step;  // sweep one entry
    logic mark_done;  // result status done
    logic load_out;   // move result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] mode;
    logic       in_range;
    logic       map_en;
    logic       map_oor;
    logic       blur_black;
    logic       div_done;
    logic       push_last;
    logic       out_busy;
  } stat_t;

  // (x * (s + 1)) >> 8
  function automatic logic [7:0] scale8(logic [7:0] x, logic [7:0] s);
    logic [16:0] p;
    p = {9'd0, x} * ({9'd0, s} + 17'd1);
    return p[15:8];
  endfunction

endpackage

// File: rtl/hsv_frame_morph_buffer_top.sv
// The sequencer carries one item at a time from input beat to output beat.
// Throughput is set by the sequencer: morph is bound by the bit-serial divider,
//   push by the one-entry-a-cycle sweep of the frame RAMs.
// Reset (async, active low) clears control, configuration and frame valid
//   bits at once; the map is undefined until loaded. No clearing pass.
// ----------------------------------------------------------------------------
// hsv_frame_morph_buffer_top
// Two-frame HSV pixel buffer with LED map, dim, push and morph read.
// ----------------------------------------------------------------------------
`include "hsv_frame_morph_buffer_top_defines.svh"

module hsv_frame_morph_buffer_top
  import hfmb_pkg::*;
#(
  parameter int unsigned NUM_PIXELS = NumPixelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_index, hue, sat, val, dim_amount, step, total_steps, map_target
  input  logic [63:0] s_axis_tdata,
  // mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_hue, out_sat, out_val
  output logic [23:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign cfg_ready_o = 1'b1;

  hfmb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  hfmb_dp #(.NumPixels(NUM_PIXELS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_mode_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_addr_i,
    .cfg_data_i,
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

  // an accepted beat starts the sequencer
  `HFMB_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, busy && !s_axis_tready)
  // ignored results carry no color
  `HFMB_ASSERT_NOW(a_ignored_black, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 24'd0)
  // a result is loaded only from the result state, never while idle
  `HFMB_ASSERT_NOW(a_load_busy, cmd.load_out, busy)

endmodule

// File: rtl/hfmb_ram.sv
// ----------------------------------------------------------------------------
// hfmb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfmb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hfmb_ctrl.sv
// ----------------------------------------------------------------------------
// hfmb_ctrl
// Sequencer: walks one item through map lookup, pixel access, divide and blend, or a push sweep.
// ----------------------------------------------------------------------------
module hfmb_ctrl
  import hfmb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;
  mode_e  mode;
  logic   map_path;

  assign mode     = mode_e'(stat_i.mode);
  assign map_path = stat_i.map_en &&
                    (mode == MODE_WR_MAP || mode == MODE_DIM);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        case (mode)
          MODE_PUSH: state_d = ST_PUSH;
          MODE_WR_MAP, MODE_WR_RAW, MODE_DIM, MODE_MORPH: begin
            if (!stat_i.in_range) state_d = ST_RESULT;
            else if (map_path)    state_d = ST_MAP;
            else                  state_d = ST_PIX;
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_MAP: begin
        state_d = stat_i.map_oor ? ST_RESULT : ST_PIX;
      end
      ST_PIX: begin
        state_d = (mode == MODE_MORPH) ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (stat_i.div_done) state_d = ST_BLEND;
      end
      ST_BLEND: state_d = ST_RESULT;
      ST_PUSH: begin
        if (stat_i.push_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_CHECK: begin
        if (mode == MODE_PUSH) begin
          cmd_o.push_clr = 1'b1;
        end else if (mode == MODE_MAP_LD) begin
          cmd_o.map_wr    = stat_i.in_range;
          cmd_o.mark_done = stat_i.in_range;
        end else begin
          cmd_o.phys_ld   = !map_path;
          cmd_o.div_start = (mode == MODE_MORPH);
        end
      end
      ST_MAP: begin
        cmd_o.use_map = 1'b1;
        cmd_o.phys_ld = 1'b1;
      end
      ST_PIX: begin
        cmd_o.px_latch = 1'b1;
        if (mode == MODE_WR_MAP || mode == MODE_WR_RAW) begin
          cmd_o.pix_write = !stat_i.blur_black;
          cmd_o.mark_done = !stat_i.blur_black;
        end else if (mode == MODE_DIM) begin
          cmd_o.dim_write = 1'b1;
          cmd_o.mark_done = 1'b1;
        end
      end
      ST_DIV: ;
      ST_BLEND: begin
        cmd_o.blend     = 1'b1;
        cmd_o.mark_done = 1'b1;
      end
      ST_PUSH: begin
        cmd_o.push_step = 1'b1;
        cmd_o.mark_done = stat_i.push_last;
      end
      ST_RESULT: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: rtl/hfmb_dp.sv
// ----------------------------------------------------------------------------
// hfmb_dp
// Datapath: frame and map RAMs, valid bits, divider, blend and output register.
// ----------------------------------------------------------------------------
module hfmb_dp
  import hfmb_pkg::*;
#(
  parameter int unsigned NumPixels = NumPixelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [2:0]  in_mode_i,
  input  logic [63:0] in_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] out_data_o,
  output logic        out_status_o
);

  localparam int unsigned Aw = (NumPixels > 1) ? $clog2(NumPixels) : 1;
  localparam int unsigned Cw = $clog2(NumPixels + 1);
  localparam logic [7:0]  NumPix8 = 8'(NumPixels);
  localparam logic [Cw-1:0] LastCnt = Cw'(NumPixels);

  // configuration
  logic       only_red_q, map_en_q;
  logic [7:0] blur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      only_red_q <= 1'b0;
      blur_q     <= 8'd0;
      map_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_ONLY_RED: only_red_q <= cfg_data_i[0];
        CFG_BLUR:     blur_q     <= cfg_data_i;
        CFG_MAP_EN:   map_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [2:0] mode_q;
  logic [7:0] idx_q, hue_q, sat_q, val_q, dim_q, step_q, total_q, target_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q   <= in_mode_i;
      idx_q    <= in_data_i[7:0];
      hue_q    <= in_data_i[15:8];
      sat_q    <= in_data_i[23:16];
      val_q    <= in_data_i[31:24];
      dim_q    <= in_data_i[39:32];
      step_q   <= in_data_i[47:40];
      total_q  <= in_data_i[55:48];
      target_q <= in_data_i[63:56];
    end
  end

  // map RAM
  logic [7:0] map_rdata;

  hfmb_ram #(.Width(8), .Depth(NumPixels)) u_map_ram (
    .clk_i,
    .we_i    (cmd_i.map_wr),
    .waddr_i (idx_q[Aw-1:0]),
    .wdata_i (target_q),
    .raddr_i (idx_q[Aw-1:0]),
    .rdata_o (map_rdata)
  );

  // physical index
  logic [7:0] phys_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.phys_ld) phys_q <= cmd_i.use_map ? map_rdata : idx_q;
  end

  // push sweep counter
  logic [Cw-1:0] cnt_q;
  logic [Cw-1:0] cnt_m1;
  logic [Aw-1:0] push_waddr;

  assign cnt_m1     = cnt_q - Cw'(1);
  assign push_waddr = cnt_m1[Aw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.push_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.push_step) begin
      cnt_q <= cnt_q + Cw'(1);
    end
  end

  // frame RAMs
  logic [Aw-1:0] pix_raddr, nxt_raddr;
  logic [23:0]   cur_rdata, nxt_rdata, nxt_wdata, cur_wdata;
  logic          nxt_we, cur_we;
  logic [NumPixels-1:0] cur_vld_q, nxt_vld_q;

  assign pix_raddr = cmd_i.use_map ? map_rdata[Aw-1:0] : idx_q[Aw-1:0];
  assign nxt_raddr = cmd_i.push_step ? cnt_q[Aw-1:0] : pix_raddr;
  assign cur_we    = cmd_i.push_step && (cnt_q != '0);
  assign cur_wdata = nxt_vld_q[push_waddr] ? nxt_rdata : 24'd0;

  hfmb_ram #(.Width(24), .Depth(NumPixels)) u_cur_ram (
    .clk_i,
    .we_i    (cur_we),
    .waddr_i (push_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (pix_raddr),
    .rdata_o (cur_rdata)
  );

  hfmb_ram #(.Width(24), .Depth(NumPixels)) u_nxt_ram (
    .clk_i,
    .we_i    (nxt_we),
    .waddr_i (phys_q[Aw-1:0]),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  // unwritten entries read as black
  hsv_t cur_px, nxt_px;
  assign cur_px = cur_vld_q[phys_q[Aw-1:0]] ? hsv_t'(cur_rdata) : '0;
  assign nxt_px = nxt_vld_q[phys_q[Aw-1:0]] ? hsv_t'(nxt_rdata) : '0;

  // color write and dim
  logic [7:0] wr_hue, wr_val;
  logic       keep_old;
  hsv_t       wr_px, dim_px;

  assign wr_hue   = only_red_q ? 8'(RedLo + scale8(hue_q, RedWidth)) : hue_q;
  assign wr_val   = (blur_q != 8'd0) ? scale8(val_q, ~blur_q) : val_q;
  assign keep_old = (blur_q != 8'd0) && (nxt_px.val > wr_val);
  assign wr_px    = '{hue: wr_hue, sat: sat_q, val: wr_val};
  assign dim_px   = '{hue: nxt_px.hue, sat: nxt_px.sat, val: scale8(nxt_px.val, ~dim_q)};
  assign nxt_we   = (cmd_i.pix_write && !keep_old) || cmd_i.dim_write;
  assign nxt_wdata = cmd_i.dim_write ? dim_px : wr_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= '0;
      nxt_vld_q <= '0;
    end else begin
      if (nxt_we) nxt_vld_q[phys_q[Aw-1:0]] <= 1'b1;
      if (cur_we) cur_vld_q[push_waddr]     <= 1'b1;
    end
  end

  // pixels held for the morph
  hsv_t cur_hold_q, nxt_hold_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.px_latch) begin
      cur_hold_q <= cur_px;
      nxt_hold_q <= nxt_px;
    end
  end

  // fract divider: step*255 / total, one quotient bit a cycle
  logic [15:0] num;
  logic [7:0]  rem_q, numlo_q, quo_q;
  logic [3:0]  div_cnt_q;
  logic [8:0]  trial;
  logic        take;

  assign num   = {step_q, 8'd0} - {8'd0, step_q};
  assign trial = {rem_q, numlo_q[7]};
  assign take  = trial >= {1'b0, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= 4'd0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= 4'd8;
    end else if (div_cnt_q != 4'd0) begin
      div_cnt_q <= div_cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q   <= num[15:8];
      numlo_q <= num[7:0];
      quo_q   <= 8'd0;
    end else if (div_cnt_q != 4'd0) begin
      rem_q   <= take ? 8'(trial - {1'b0, total_q}) : trial[7:0];
      numlo_q <= {numlo_q[6:0], 1'b0};
      quo_q   <= {quo_q[6:0], take};
    end
  end

  // blend
  logic [7:0] fract, cw, ccw, hue_span, hue_step, sat_bl, val_bl, hue_bl;

  assign fract    = (step_q >= total_q) ? 8'd255 : quo_q;
  assign cw       = nxt_hold_q.hue - cur_hold_q.hue;
  assign ccw      = cur_hold_q.hue - nxt_hold_q.hue;
  assign hue_span = (cw <= ccw) ? cw : ccw;
  assign hue_step = scale8(fract, hue_span);
  assign hue_bl   = (cw <= ccw) ? cur_hold_q.hue + hue_step : cur_hold_q.hue - hue_step;

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [7:0] f);
    logic [7:0] r;
    if (b > a) r = a + scale8(b - a, f);
    else       r = a - scale8(a - b, f);
    return r;
  endfunction

  assign sat_bl = lerp8(cur_hold_q.sat, nxt_hold_q.sat, fract);
  assign val_bl = lerp8(cur_hold_q.val, nxt_hold_q.val, fract);

  // result register
  hsv_t res_q;
  logic res_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      res_q        <= '0;
      res_status_q <= 1'b1;
    end else begin
      if (cmd_i.mark_done) res_status_q <= 1'b0;
      if (cmd_i.blend) begin
        if (cur_hold_q == nxt_hold_q || fract == 8'd0) res_q <= cur_hold_q;
        else if (fract == 8'd255)                       res_q <= nxt_hold_q;
        else res_q <= '{hue: hue_bl, sat: sat_bl, val: val_bl};
      end
    end
  end

  // output register
  logic        out_valid_q, out_status_q;
  logic [23:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= {res_q.val, res_q.sat, res_q.hue};
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  // status to controller
  assign stat_o.mode       = mode_q;
  assign stat_o.in_range   = idx_q < NumPix8;
  assign stat_o.map_en     = map_en_q;
  assign stat_o.map_oor    = map_rdata >= NumPix8;
  assign stat_o.blur_black = (blur_q != 8'd0) && (val_q == 8'd0);
  assign stat_o.div_done   = (div_cnt_q == 4'd0);
  assign stat_o.push_last  = (cnt_q == LastCnt);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

endmodule
